### sv/dtq_pkg.sv
// ----------------------------------------------------------------------------
// dtq_pkg
// Shared constants, codes and types of the deadline timer queue.
// ----------------------------------------------------------------------------
package dtq_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int OP_W    = 2;
    localparam int KIND_W  = 3;
    localparam int TIME_W  = 48;
    localparam int ID_W    = 32;
    localparam int DELAY_W = 32;
    localparam int SLEEP_W = 49;
    localparam int ENTRY_W = TIME_W + ID_W;

    localparam int S_DATA_W = 160;
    localparam int M_DATA_W = 136;

    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_EXPIRE = 2'd2;

    localparam logic [KIND_W-1:0] KIND_ADDED     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DELETED   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_NOT_FOUND = 3'd2;
    localparam logic [KIND_W-1:0] KIND_FIRED     = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DONE      = 3'd4;
    localparam logic [KIND_W-1:0] KIND_FULL      = 3'd5;

    typedef struct packed {
        logic              done;
        logic              found;
        logic [IDX_W-1:0]  slot;
        logic [TIME_W-1:0] deadline;
        logic [ID_W-1:0]   ident;
        logic              match_found;
        logic [IDX_W-1:0]  match_slot;
    } scan_res_t;

endpackage

### sv/dtq_ram.sv
// ----------------------------------------------------------------------------
// dtq_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module dtq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### sv/dtq_scan.sv
// ----------------------------------------------------------------------------
// dtq_scan
// Sweeps the timer table once, finding the earliest live entry (other than the
// first match) and the lowest-slot entry that matches a delete target.
// ----------------------------------------------------------------------------
module dtq_scan (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          match_en,
    input  logic [dtq_pkg::TIME_W-1:0]    target_expire,
    input  logic [dtq_pkg::ID_W-1:0]      target_id,
    input  logic [dtq_pkg::CAPACITY-1:0]  valid,
    output logic                          rd_en,
    output logic [dtq_pkg::IDX_W-1:0]     rd_addr,
    input  logic [dtq_pkg::ENTRY_W-1:0]   rd_data,
    output dtq_pkg::scan_res_t            res
);

    logic                        active_reg;
    logic [dtq_pkg::CNT_W-1:0]   cnt_reg;
    logic                        pend_reg;
    logic                        pend_live_reg;
    logic [dtq_pkg::IDX_W-1:0]   pend_slot_reg;
    logic                        done_reg;
    logic                        found_reg;
    logic [dtq_pkg::IDX_W-1:0]   slot_reg;
    logic [dtq_pkg::TIME_W-1:0]  dl_reg;
    logic [dtq_pkg::ID_W-1:0]    id_reg;
    logic                        mfound_reg;
    logic [dtq_pkg::IDX_W-1:0]   mslot_reg;

    logic [dtq_pkg::TIME_W-1:0]  ent_dl;
    logic [dtq_pkg::ID_W-1:0]    ent_id;
    logic                        is_match;
    logic                        better;

    assign rd_en   = active_reg && (cnt_reg < dtq_pkg::CNT_W'(dtq_pkg::CAPACITY));
    assign rd_addr = cnt_reg[dtq_pkg::IDX_W-1:0];

    assign ent_dl   = rd_data[dtq_pkg::TIME_W-1:0];
    assign ent_id   = rd_data[dtq_pkg::ENTRY_W-1:dtq_pkg::TIME_W];
    assign is_match = match_en && (ent_dl == target_expire) && (ent_id == target_id);
    assign better   = !found_reg || (ent_dl < dl_reg) || ((ent_dl == dl_reg) && (ent_id < id_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            pend_live_reg <= 1'b0;
            pend_slot_reg <= '0;
            done_reg      <= 1'b0;
            found_reg     <= 1'b0;
            slot_reg      <= '0;
            dl_reg        <= '0;
            id_reg        <= '0;
            mfound_reg    <= 1'b0;
            mslot_reg     <= '0;
        end
        else if (start)
        begin
            active_reg <= 1'b1;
            cnt_reg    <= '0;
            pend_reg   <= 1'b0;
            done_reg   <= 1'b0;
            found_reg  <= 1'b0;
            mfound_reg <= 1'b0;
        end
        else if (active_reg)
        begin
            pend_reg <= rd_en;
            if (rd_en)
            begin
                cnt_reg       <= cnt_reg + dtq_pkg::CNT_W'(1);
                pend_slot_reg <= rd_addr;
                pend_live_reg <= valid[rd_addr];
            end
            if (pend_reg && pend_live_reg)
            begin
                if (is_match && !mfound_reg)
                begin
                    mfound_reg <= 1'b1;
                    mslot_reg  <= pend_slot_reg;
                end
                else if (better)
                begin
                    found_reg <= 1'b1;
                    slot_reg  <= pend_slot_reg;
                    dl_reg    <= ent_dl;
                    id_reg    <= ent_id;
                end
            end
            if (!rd_en && !pend_reg)
            begin
                active_reg <= 1'b0;
                done_reg   <= 1'b1;
            end
        end
    end

    assign res.done        = done_reg;
    assign res.found       = found_reg;
    assign res.slot        = slot_reg;
    assign res.deadline    = dl_reg;
    assign res.ident       = id_reg;
    assign res.match_found = mfound_reg;
    assign res.match_slot  = mslot_reg;

endmodule

### sv/deadline_timer_queue_unit.sv
// ----------------------------------------------------------------------------
// deadline_timer_queue_unit
// Table of pending timers kept in a RAM, served in deadline and id order.
// ----------------------------------------------------------------------------
//  Channel  Direction  Payload
//  s_*      in         tuser: opcode; tdata: now, delay_ms, target_expire, target_id
//  m_*      out        tuser: kind; tdata: timer_id, timer_expire, sleep_ms; tlast: last
//
//  Every item sweeps the table through the single RAM read port. An add
//  first writes its entry to a free slot, if there is one, and each timer
//  that an expire fires starts another sweep.
//  Reset clears the valid bits and the id counter; the RAM is not cleared.
//  A stalled output holds the block before its next result; a new item is
//  taken while the last result still waits.
// ----------------------------------------------------------------------------
module deadline_timer_queue_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // tdata fields from bit 0: now, delay_ms, target_expire, target_id.
    input  logic [dtq_pkg::S_DATA_W-1:0]    s_tdata,
    // tuser fields from bit 0: opcode.
    input  logic [dtq_pkg::OP_W-1:0]        s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // tdata fields from bit 0: timer_id, timer_expire, sleep_ms, zero fill.
    output logic [dtq_pkg::M_DATA_W-1:0]    m_tdata,
    // tuser fields from bit 0: kind.
    output logic [dtq_pkg::KIND_W-1:0]      m_tuser,
    output logic                            m_tlast
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WRITE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    state_t                          state_reg;
    logic [dtq_pkg::OP_W-1:0]        op_reg;
    logic [dtq_pkg::TIME_W-1:0]      now_reg;
    logic [dtq_pkg::DELAY_W-1:0]     delay_reg;
    logic [dtq_pkg::TIME_W-1:0]      texp_reg;
    logic [dtq_pkg::ID_W-1:0]        tid_reg;
    logic                            full_reg;
    logic [dtq_pkg::IDX_W-1:0]       slot_reg;
    logic [dtq_pkg::ID_W-1:0]        next_id_reg;
    logic [dtq_pkg::ID_W-1:0]        res_id_reg;
    logic [dtq_pkg::TIME_W-1:0]      res_dl_reg;
    logic [dtq_pkg::CAPACITY-1:0]    valid_reg;
    logic                            start_reg;

    logic                            m_tvalid_reg;
    logic [dtq_pkg::KIND_W-1:0]      m_kind_reg;
    logic [dtq_pkg::ID_W-1:0]        m_id_reg;
    logic [dtq_pkg::TIME_W-1:0]      m_dl_reg;
    logic [dtq_pkg::SLEEP_W-1:0]     m_sleep_reg;
    logic                            m_last_reg;

    logic                            any_free;
    logic [dtq_pkg::IDX_W-1:0]       free_slot;
    logic [dtq_pkg::TIME_W:0]        dl_sum;
    logic [dtq_pkg::TIME_W-1:0]      dl_sat;
    logic [dtq_pkg::ID_W-1:0]        id_inc;
    logic [dtq_pkg::SLEEP_W-1:0]     sleep_val;
    logic                            due;
    logic                            out_free;
    logic                            accept;

    logic                            rd_en;
    logic [dtq_pkg::IDX_W-1:0]       rd_addr;
    logic [dtq_pkg::ENTRY_W-1:0]     rd_data;
    logic                            wr_en;
    dtq_pkg::scan_res_t              sres;

    always_comb
    begin
        any_free  = 1'b0;
        free_slot = '0;
        for (int i = dtq_pkg::CAPACITY - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                any_free  = 1'b1;
                free_slot = dtq_pkg::IDX_W'(i);
            end
        end
    end

    assign dl_sum = {1'b0, now_reg}
                  + {{(dtq_pkg::TIME_W + 1 - dtq_pkg::DELAY_W){1'b0}}, delay_reg};
    assign dl_sat = dl_sum[dtq_pkg::TIME_W] ? '1 : dl_sum[dtq_pkg::TIME_W-1:0];
    assign id_inc = next_id_reg + dtq_pkg::ID_W'(1);

    always_comb
    begin
        if (!sres.found)
        begin
            sleep_val = '1;
        end
        else if (sres.deadline > now_reg)
        begin
            sleep_val = {1'b0, sres.deadline - now_reg};
        end
        else
        begin
            sleep_val = '0;
        end
    end

    assign due      = sres.found && (sres.deadline <= now_reg);
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign wr_en    = (state_reg == ST_WRITE);

    dtq_ram #(
        .WIDTH (dtq_pkg::ENTRY_W),
        .DEPTH (dtq_pkg::CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (slot_reg),
        .wdata ({id_inc, dl_sat}),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    dtq_scan u_scan (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start_reg),
        .match_en      (op_reg == dtq_pkg::OP_DELETE),
        .target_expire (texp_reg),
        .target_id     (tid_reg),
        .valid         (valid_reg),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data),
        .res           (sres)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            op_reg       <= '0;
            now_reg      <= '0;
            delay_reg    <= '0;
            texp_reg     <= '0;
            tid_reg      <= '0;
            full_reg     <= 1'b0;
            slot_reg     <= '0;
            next_id_reg  <= '0;
            res_id_reg   <= '0;
            res_dl_reg   <= '0;
            valid_reg    <= '0;
            start_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
            m_kind_reg   <= '0;
            m_id_reg     <= '0;
            m_dl_reg     <= '0;
            m_sleep_reg  <= '0;
            m_last_reg   <= 1'b0;
        end
        else
        begin
            if (m_tvalid_reg && m_tready && (state_reg != ST_FINISH))
            begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        op_reg     <= s_tuser;
                        now_reg    <= s_tdata[47:0];
                        delay_reg  <= s_tdata[79:48];
                        texp_reg   <= s_tdata[127:80];
                        tid_reg    <= s_tdata[159:128];
                        full_reg   <= (s_tuser == dtq_pkg::OP_ADD) && !any_free;
                        res_id_reg <= '0;
                        res_dl_reg <= '0;
                        slot_reg   <= free_slot;
                        start_reg  <= !((s_tuser == dtq_pkg::OP_ADD) && any_free);
                        if (s_tuser == dtq_pkg::OP_ADD && any_free)
                        begin
                            state_reg <= ST_WRITE;
                        end
                        else
                        begin
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                ST_WRITE:
                begin
                    valid_reg[slot_reg] <= 1'b1;
                    next_id_reg         <= id_inc;
                    res_id_reg          <= id_inc;
                    res_dl_reg          <= dl_sat;
                    start_reg           <= 1'b1;
                    state_reg           <= ST_SCAN;
                end
                ST_SCAN:
                begin
                    start_reg <= 1'b0;
                    if (sres.done && !start_reg)
                    begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        if (op_reg == dtq_pkg::OP_EXPIRE && due)
                        begin
                            m_kind_reg            <= dtq_pkg::KIND_FIRED;
                            m_id_reg              <= sres.ident;
                            m_dl_reg              <= sres.deadline;
                            m_sleep_reg           <= '0;
                            m_last_reg            <= 1'b0;
                            valid_reg[sres.slot]  <= 1'b0;
                            start_reg             <= 1'b1;
                            state_reg             <= ST_SCAN;
                        end
                        else
                        begin
                            m_id_reg    <= res_id_reg;
                            m_dl_reg    <= res_dl_reg;
                            m_sleep_reg <= sleep_val;
                            m_last_reg  <= 1'b1;
                            start_reg   <= 1'b0;
                            state_reg   <= ST_IDLE;
                            unique case (op_reg)
                                dtq_pkg::OP_ADD:
                                begin
                                    m_kind_reg <= full_reg ? dtq_pkg::KIND_FULL
                                                           : dtq_pkg::KIND_ADDED;
                                end
                                dtq_pkg::OP_DELETE:
                                begin
                                    if (sres.match_found)
                                    begin
                                        m_kind_reg                 <= dtq_pkg::KIND_DELETED;
                                        valid_reg[sres.match_slot] <= 1'b0;
                                    end
                                    else
                                    begin
                                        m_kind_reg <= dtq_pkg::KIND_NOT_FOUND;
                                    end
                                end
                                default:
                                begin
                                    m_kind_reg <= dtq_pkg::KIND_DONE;
                                end
                            endcase
                        end
                    end
                end
                default:
                begin
                    start_reg <= 1'b0;
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {{(dtq_pkg::M_DATA_W - dtq_pkg::SLEEP_W - dtq_pkg::TIME_W
                         - dtq_pkg::ID_W){1'b0}}, m_sleep_reg, m_dl_reg, m_id_reg};

endmodule
